// ----- hdl/csx_pkg.sv -----
// Package: shared types and constants for the ChaCha20 stream XOR block.
package csx_pkg;

    localparam int unsigned REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_KEY0    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY1    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY2    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KEY3    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_NONCE_L = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_NONCE_H = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_COUNTER = 3'd6;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam int unsigned DOUBLE_ROUNDS = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_READY
    } t_core_state;

    // Column or diagonal quarter-round word indexes, chosen by step 0..7.
    function automatic logic [15:0] qr_idx(input logic [2:0] step);
        logic [15:0] r;
        begin
            case (step)
                3'd0: r = {4'd0, 4'd4, 4'd8, 4'd12};
                3'd1: r = {4'd1, 4'd5, 4'd9, 4'd13};
                3'd2: r = {4'd2, 4'd6, 4'd10, 4'd14};
                3'd3: r = {4'd3, 4'd7, 4'd11, 4'd15};
                3'd4: r = {4'd0, 4'd5, 4'd10, 4'd15};
                3'd5: r = {4'd1, 4'd6, 4'd11, 4'd12};
                3'd6: r = {4'd2, 4'd7, 4'd8, 4'd13};
                default: r = {4'd3, 4'd4, 4'd9, 4'd14};
            endcase
            return r;
        end
    endfunction

endpackage

// ----- hdl/csx_front.sv -----
// Front: input queue that accepts words and holds them for the back part.
module csx_front #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  csx_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_take,
    output logic           o_avail,
    output csx_pkg::t_item o_item
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    csx_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]  r_wp, n_wp, r_rp, n_rp;
    logic [AW:0]    r_cnt, n_cnt;
    logic           w_wr, w_rd;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_avail;

    always_comb begin
        n_wp  = w_wr ? ((r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1) : r_wp;
        n_rp  = w_rd ? ((r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1) : r_rp;
        n_cnt = r_cnt + (AW+1)'(w_wr) - (AW+1)'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule

// ----- hdl/csx_core.sv -----
// Back: keystream generator with one shared quarter-round unit and byte XOR.
module csx_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [63:0]    i_cfg_data,
    input  logic           i_avail,
    input  csx_pkg::t_item i_item,
    output logic           o_take,
    output logic           o_valid,
    output csx_pkg::t_item o_item,
    input  logic           i_pop
);
    logic [255:0] r_key;
    logic [95:0]  r_nonce;
    logic [31:0]  r_ctr;
    logic [31:0]  r_w   [16];
    logic [31:0]  r_ks  [16];
    logic [5:0]   r_pos;
    logic [2:0]   r_step;
    logic [3:0]   r_dr;
    logic         r_ovalid;
    csx_pkg::t_item r_out;

    csx_pkg::t_core_state r_st, n_st;

    logic [31:0] w_init [16];
    logic [15:0] w_ix;
    logic [31:0] a0, b0, c0, d0, a1, b1, c1, d1, d2, c2, b2, a3, d3, c3, b3;
    logic [31:0] w_ksw;
    logic [7:0]  w_ksb;
    logic        w_emit;

    always_comb begin
        w_init[0]  = csx_pkg::SIGMA0;
        w_init[1]  = csx_pkg::SIGMA1;
        w_init[2]  = csx_pkg::SIGMA2;
        w_init[3]  = csx_pkg::SIGMA3;
        for (int k = 0; k < 8; k++) begin
            w_init[4+k] = r_key[32*k +: 32];
        end
        w_init[12] = r_ctr;
        w_init[13] = r_nonce[31:0];
        w_init[14] = r_nonce[63:32];
        w_init[15] = r_nonce[95:64];
    end

    assign w_ix = csx_pkg::qr_idx(r_step);

    always_comb begin
        a0 = r_w[w_ix[15:12]];
        b0 = r_w[w_ix[11:8]];
        c0 = r_w[w_ix[7:4]];
        d0 = r_w[w_ix[3:0]];
        a1 = a0 + b0;
        d1 = d0 ^ a1;  d1 = {d1[15:0], d1[31:16]};
        c1 = c0 + d1;
        b1 = b0 ^ c1;  b1 = {b1[19:0], b1[31:20]};
        a3 = a1 + b1;
        d2 = d1 ^ a3;  d3 = {d2[23:0], d2[31:24]};
        c3 = c1 + d3;
        b2 = b1 ^ c3;  b3 = {b2[24:0], b2[31:25]};
        c2 = c3;
    end

    assign w_ksw  = r_ks[r_pos[5:2]];
    assign w_ksb  = w_ksw[8*r_pos[1:0] +: 8];
    assign w_emit = (r_st == csx_pkg::ST_READY) && i_avail && (!r_ovalid || i_pop);
    assign o_take = w_emit;
    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    always_comb begin
        n_st = r_st;
        case (r_st)
            csx_pkg::ST_IDLE:  if (i_avail) n_st = csx_pkg::ST_ROUND;
            csx_pkg::ST_ROUND: begin
                if (r_step == 3'd7 && r_dr == 4'(csx_pkg::DOUBLE_ROUNDS - 1)) begin
                    n_st = csx_pkg::ST_FINAL;
                end
            end
            csx_pkg::ST_FINAL: n_st = csx_pkg::ST_READY;
            csx_pkg::ST_READY: begin
                if (w_emit && (i_item.last || r_pos == 6'd63)) n_st = csx_pkg::ST_IDLE;
            end
            default: n_st = csx_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= csx_pkg::ST_IDLE;
            r_key    <= '0;
            r_nonce  <= '0;
            r_ctr    <= '0;
            r_pos    <= '0;
            r_step   <= '0;
            r_dr     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == csx_pkg::ST_ROUND) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd7) r_dr <= r_dr + 4'd1;
            end else begin
                r_step <= '0;
                r_dr   <= '0;
            end
            if (r_st == csx_pkg::ST_FINAL) begin
                r_ctr <= r_ctr + 32'd1;
                r_pos <= '0;
            end
            if (w_emit) begin
                r_pos <= r_pos + 6'd1;
            end
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    csx_pkg::REG_KEY0:    r_key[63:0]    <= i_cfg_data;
                    csx_pkg::REG_KEY1:    r_key[127:64]  <= i_cfg_data;
                    csx_pkg::REG_KEY2:    r_key[191:128] <= i_cfg_data;
                    csx_pkg::REG_KEY3:    r_key[255:192] <= i_cfg_data;
                    csx_pkg::REG_NONCE_L: r_nonce[63:0]  <= i_cfg_data;
                    csx_pkg::REG_NONCE_H: r_nonce[95:64] <= i_cfg_data[31:0];
                    csx_pkg::REG_COUNTER: r_ctr          <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == csx_pkg::ST_IDLE) begin
            for (int k = 0; k < 16; k++) r_w[k] <= w_init[k];
        end else if (r_st == csx_pkg::ST_ROUND) begin
            r_w[w_ix[15:12]] <= a3;
            r_w[w_ix[11:8]]  <= b3;
            r_w[w_ix[7:4]]   <= c2;
            r_w[w_ix[3:0]]   <= d3;
        end
        if (r_st == csx_pkg::ST_FINAL) begin
            for (int k = 0; k < 16; k++) r_ks[k] <= r_w[k] + w_init[k];
        end
        if (w_emit) begin
            r_out.data <= i_item.data ^ w_ksb;
            r_out.last <= i_item.last;
        end
    end
endmodule

// ----- hdl/chacha20_stream_xor.sv -----
// Top level: ChaCha20 stream XOR with input queue and keystream back end.
//  channel | direction | handshake          | payload
//  input   | in        | push / full        | i_data_in, i_end_of_message
//  result  | out       | empty / pop        | o_data_out, o_last_out
//  config  | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
// A keystream block is a load, 80 quarter rounds on one unit and an add;
// then one byte per cycle while not stalled, up to 64 bytes or end of message.
// Reset is synchronous, active low; clears control state, key, nonce and counter.
// The input queue accepts bytes while the block function runs.
module chacha20_stream_xor #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_in,
    input  logic        i_end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_data_out,
    output logic        o_last_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    csx_pkg::t_item w_in, w_q, w_out;
    logic w_avail, w_take, w_valid;

    assign w_in.data = i_data_in;
    assign w_in.last = i_end_of_message;

    csx_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_item(w_in),
        .o_full(full), .i_take(w_take), .o_avail(w_avail), .o_item(w_q)
    );

    csx_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .i_avail(w_avail),
        .i_item(w_q), .o_take(w_take), .o_valid(w_valid), .o_item(w_out),
        .i_pop(pop)
    );

    assign empty      = !w_valid;
    assign o_data_out = w_out.data;
    assign o_last_out = w_out.last;
endmodule

// ----- hdl/csx_checker.sv -----
// Checker: port-level properties of the ChaCha20 stream XOR block.
module csx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_data_out,
    input logic       o_last_out
);
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty) else $error("result shown after reset");
    a_not_full_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !full) else $error("queue full after reset");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_data_out) && $stable(o_last_out)))
        else $error("waiting result changed");
endmodule

bind chacha20_stream_xor csx_checker u_csx_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .full(full),
    .empty(empty), .pop(pop), .o_data_out(o_data_out), .o_last_out(o_last_out)
);

// ----- tb/sv/chacha20_stream_xor_test.sv -----
// Testbench for chacha20_stream_xor: random byte streams checked against a ChaCha20 predictor.
`timescale 1ns / 100ps

class cipher_scoreboard;
    logic [63:0] key [4];
    logic [63:0] nonce_lo;
    logic [31:0] nonce_hi;
    logic [31:0] blk_ctr;
    logic [31:0] ks_words [16];
    logic [31:0] w [16];
    int unsigned byte_pos;
    bit          ks_live;
    logic [8:0]  expected_bytes [$];
    int unsigned errors;

    function new();
        foreach (key[i]) key[i] = '0;
        nonce_lo = '0;
        nonce_hi = '0;
        blk_ctr  = '0;
        byte_pos = 0;
        ks_live  = 0;
        errors   = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] v);
        case (idx)
            csx_pkg::REG_KEY0:    key[0] = v;
            csx_pkg::REG_KEY1:    key[1] = v;
            csx_pkg::REG_KEY2:    key[2] = v;
            csx_pkg::REG_KEY3:    key[3] = v;
            csx_pkg::REG_NONCE_L: nonce_lo = v;
            csx_pkg::REG_NONCE_H: nonce_hi = v[31:0];
            csx_pkg::REG_COUNTER: blk_ctr = v[31:0];
            default: ;
        endcase
    endfunction

    function logic [31:0] rotl(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function void quarter(int a, int b, int c, int d);
        w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 16);
        w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 12);
        w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 8);
        w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 7);
    endfunction

    function void next_keystream_block();
        logic [31:0] init [16];
        init[0] = csx_pkg::SIGMA0;
        init[1] = csx_pkg::SIGMA1;
        init[2] = csx_pkg::SIGMA2;
        init[3] = csx_pkg::SIGMA3;
        for (int i = 0; i < 4; i++) begin
            init[4 + 2*i] = key[i][31:0];
            init[5 + 2*i] = key[i][63:32];
        end
        init[12] = blk_ctr;
        init[13] = nonce_lo[31:0];
        init[14] = nonce_lo[63:32];
        init[15] = nonce_hi;
        w = init;
        for (int r = 0; r < 10; r++) begin
            quarter(0, 4, 8, 12);
            quarter(1, 5, 9, 13);
            quarter(2, 6, 10, 14);
            quarter(3, 7, 11, 15);
            quarter(0, 5, 10, 15);
            quarter(1, 6, 11, 12);
            quarter(2, 7, 8, 13);
            quarter(3, 4, 9, 14);
        end
        foreach (ks_words[i]) ks_words[i] = w[i] + init[i];
        blk_ctr = blk_ctr + 32'd1;
    endfunction

    function void note_input(logic [7:0] data, logic eom);
        logic [7:0] ks;
        if (!ks_live) begin
            next_keystream_block();
            ks_live  = 1;
            byte_pos = 0;
        end
        ks = 8'(ks_words[byte_pos / 4] >> (8 * (byte_pos % 4)));
        expected_bytes.push_back({eom, data ^ ks});
        byte_pos++;
        if (byte_pos >= 64 || eom) begin
            ks_live  = 0;
            byte_pos = 0;
        end
    endfunction

    function void check_output(logic [7:0] data, logic last);
        logic [8:0] e;
        if (expected_bytes.size() == 0) begin
            $error("unexpected output word data_out=%h last_out=%b", data, last);
            errors++;
            return;
        end
        e = expected_bytes.pop_front();
        if (data !== e[7:0]) begin
            $error("data_out expected %h actual %h", e[7:0], data);
            errors++;
        end
        if (last !== e[8]) begin
            $error("last_out expected %b actual %b", e[8], last);
            errors++;
        end
    endfunction
endclass

module chacha20_stream_xor_test;

    localparam int WATCHDOG_LIMIT = 4000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        push = 0;
    logic        full;
    logic [7:0]  i_data_in = '0;
    logic        i_end_of_message = 0;
    logic        empty;
    logic        pop = 0;
    logic [7:0]  o_data_out;
    logic        o_last_out;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;

    cipher_scoreboard sb = new();
    logic [8:0] tx_bytes [$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_go = 0;
    bit          hold_armed = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;

    chacha20_stream_xor uut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // sender
    always @(posedge i_clk) begin
        if (push && !full) begin
            sb.note_input(i_data_in, i_end_of_message);
            void'(tx_bytes.pop_front());
        end
        if (i_rst_n && tx_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            push             <= 1;
            i_data_in        <= tx_bytes[0][7:0];
            i_end_of_message <= tx_bytes[0][8];
        end else begin
            push <= 0;
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (pop && !empty)
            sb.check_output(o_data_out, o_last_out);
        if (hold_go && !hold_armed) begin
            hold_armed <= 1;
            hold_left  <= 400;
            pop        <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pop <= 0;
        end else begin
            pop <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task cfg_write(logic [2:0] idx, logic [63:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        sb.write_reg(idx, v);
    endtask

    task cfg_release();
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task load_config(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3,
                     logic [63:0] n_lo, logic [31:0] n_hi, logic [31:0] ctr);
        cfg_write(csx_pkg::REG_KEY0, k0);
        cfg_write(csx_pkg::REG_KEY1, k1);
        cfg_write(csx_pkg::REG_KEY2, k2);
        cfg_write(csx_pkg::REG_KEY3, k3);
        cfg_write(csx_pkg::REG_NONCE_L, n_lo);
        cfg_write(csx_pkg::REG_NONCE_H, {32'h0, n_hi});
        cfg_write(csx_pkg::REG_COUNTER, {32'h0, ctr});
        cfg_write(3'd7, {$urandom, $urandom});
        cfg_release();
    endtask

    task queue_message(int len);
        for (int i = 0; i < len; i++)
            tx_bytes.push_back({i == len - 1, 8'($urandom)});
    endtask

    task queue_random(int n_bytes);
        int left;
        int len;
        left = n_bytes;
        while (left > 0) begin
            if ($urandom_range(9) == 0) begin
                tx_bytes.push_back({1'($urandom), 8'($urandom)});
                left--;
            end else begin
                len = ($urandom_range(3) == 0) ? $urandom_range(60, 70)
                                               : $urandom_range(1, 20);
                queue_message(len);
                left -= len;
            end
        end
    endtask

    task drain();
        while (tx_bytes.size() > 0 || sb.expected_bytes.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function logic [63:0] r64();
        return {$urandom, $urandom};
    endfunction

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: field extremes, single-byte messages and partial blocks
        tx_bytes.push_back({1'b0, 8'h00});
        tx_bytes.push_back({1'b0, 8'hff});
        tx_bytes.push_back({1'b1, 8'h55});
        tx_bytes.push_back({1'b1, 8'haa});
        tx_bytes.push_back({1'b1, 8'h00});
        drain();
        load_config('1, '1, '1, '1, '1, '1, 32'hffff_ffff);
        queue_message(1);
        tx_bytes.push_back({1'b0, 8'hff});
        drain();
        load_config('0, '0, '0, '0, '0, '0, 32'hffff_ffff);
        for (int i = 0; i < 20; i++)
            tx_bytes.push_back({1'b0, 8'(i * 13)});
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 69; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 69; end
                3: begin send_idle_pct = 14; recv_idle_pct = 14; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (ph == 1)
                load_config('1, '0, '1, '0, '1, '0, 32'h0);
            else
                load_config(r64(), r64(), r64(), r64(), r64(), $urandom,
                            ($urandom_range(1) ? 32'hffff_ffff - $urandom_range(2) : $urandom));
            queue_random(ph == 4 ? 40 : 85);
            if (ph == 4)
                hold_go = 1;
            drain();
        end

        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
